@@ src/pspp_pkg.sv @@
// Package with shared types and constants for the synced sensor packet parser.
`timescale 1ns / 1ps

package pspp_pkg;

    // Packet format.
    localparam int PREFIX_LEN   = 4;
    localparam int NUM_CHANNELS = 8;
    localparam int NUM_ANALOG   = 8;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;

    localparam int PCNT_W = $clog2(PREFIX_LEN + 1);
    localparam int IDX_W  = (NUM_ANALOG > 1) ? $clog2(NUM_ANALOG) : 1;

    localparam logic [PCNT_W-1:0] PREFIX_LAST = PCNT_W'(PREFIX_LEN - 1);
    localparam logic [7:0]        CHAN_LIMIT  = 8'(NUM_CHANNELS);
    localparam logic [IDX_W-1:0]  INDEX_LAST  = IDX_W'(NUM_ANALOG - 1);

    // Field widths.
    localparam int CHAN_W   = 3;
    localparam int AIDX_W   = 3;
    localparam int RAW_W    = 16;
    localparam int SCALED_W = 23;
    localparam int DATA_W   = 48;

    // Rounded divide by 1023 of a Q16 value: the half step 511 is added, then the
    // 32-bit numerator is multiplied by ceil(2^42 / 1023) = 2^32 + SCALE_MUL_LO and
    // shifted down by 42. That reciprocal is exact for every 32-bit numerator.
    localparam logic [15:0] ROUND_HALF   = 16'd511;
    localparam logic [22:0] SCALE_MUL_LO = 23'd4198405;
    localparam int          SCALE_SHIFT  = 42;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_CHAN,
        ST_PEDAL,
        ST_LOW,
        ST_HIGH
    } pspp_state_t;

    typedef struct packed {
        logic                valid;
        logic [CHAN_W-1:0]   channel;
        logic [AIDX_W-1:0]   analog_index;
        logic [RAW_W-1:0]    raw_value;
        logic [SCALED_W-1:0] scaled_value;
        logic                pedal_down;
        logic                pedal_changed;
        logic                last_of_packet;
    } pspp_result_t;

endpackage

@@ src/pspp_parser.sv @@
// Packet framing state machine and value scaling for the sensor packet parser.
`timescale 1ns / 1ps

module pspp_parser
    import pspp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  logic [7:0]   rx_byte,
    output pspp_result_t res
);

    pspp_state_t       state_reg, state_next;
    logic [PCNT_W-1:0] prefix_cnt_reg, prefix_cnt_next;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic [CHAN_W-1:0] held_channel_reg, held_channel_next;
    logic [7:0]        held_low_reg, held_low_next;
    logic              pedal_prev_reg, pedal_prev_next;
    logic              pedal_flag_reg, pedal_flag_next;

    logic [PCNT_W-1:0] hunt_cnt;
    logic              pedal_now;
    logic [31:0]       numer;
    logic [54:0]       prod;
    logic [64:0]       scale_sum;

    // A rejected channel byte is hunted again from an empty prefix count.
    assign hunt_cnt  = (state_reg == ST_CHAN) ? '0 : prefix_cnt_reg;
    assign pedal_now = (rx_byte != 8'd0);

    always_comb begin
        state_next        = state_reg;
        prefix_cnt_next   = prefix_cnt_reg;
        index_next        = index_reg;
        held_channel_next = held_channel_reg;
        held_low_next     = held_low_reg;
        pedal_prev_next   = pedal_prev_reg;
        pedal_flag_next   = pedal_flag_reg;
        case (state_reg)
            ST_HUNT, ST_CHAN: begin
                if ((state_reg == ST_CHAN) && (rx_byte < CHAN_LIMIT)) begin
                    held_channel_next = rx_byte[CHAN_W-1:0];
                    prefix_cnt_next   = '0;
                    state_next        = ST_PEDAL;
                end else if (rx_byte == SYNC_BYTE) begin
                    if (hunt_cnt == PREFIX_LAST) begin
                        prefix_cnt_next = '0;
                        state_next      = ST_CHAN;
                    end else begin
                        prefix_cnt_next = hunt_cnt + 1'b1;
                        state_next      = ST_HUNT;
                    end
                end else begin
                    prefix_cnt_next = '0;
                    state_next      = ST_HUNT;
                end
            end
            ST_PEDAL: begin
                pedal_flag_next = pedal_now ^ pedal_prev_reg;
                pedal_prev_next = pedal_now;
                index_next      = '0;
                state_next      = ST_LOW;
            end
            ST_LOW: begin
                held_low_next = rx_byte;
                state_next    = ST_HIGH;
            end
            ST_HIGH: begin
                if (index_reg == INDEX_LAST) begin
                    prefix_cnt_next = '0;
                    state_next      = ST_HUNT;
                end else begin
                    index_next = index_reg + 1'b1;
                    state_next = ST_LOW;
                end
            end
            default: begin
                prefix_cnt_next = '0;
                state_next      = ST_HUNT;
            end
        endcase
    end

    assign numer     = {rx_byte, held_low_reg, ROUND_HALF};
    assign prod      = numer * SCALE_MUL_LO;
    assign scale_sum = {1'b0, numer, 32'd0} + 65'(prod);

    always_comb begin
        res                = '0;
        res.channel        = held_channel_reg;
        res.analog_index   = AIDX_W'(index_reg);
        res.raw_value      = {rx_byte, held_low_reg};
        res.scaled_value   = scale_sum[SCALE_SHIFT +: SCALED_W];
        res.pedal_down     = pedal_prev_reg;
        res.pedal_changed  = pedal_flag_reg;
        res.last_of_packet = (index_reg == INDEX_LAST);
        case (state_reg)
            ST_HIGH: res.valid = 1'b1;
            default: res.valid = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_HUNT;
            prefix_cnt_reg <= '0;
            index_reg      <= '0;
            pedal_prev_reg <= 1'b0;
            pedal_flag_reg <= 1'b0;
        end else if (step) begin
            state_reg      <= state_next;
            prefix_cnt_reg <= prefix_cnt_next;
            index_reg      <= index_next;
            pedal_prev_reg <= pedal_prev_next;
            pedal_flag_reg <= pedal_flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            held_channel_reg <= held_channel_next;
            held_low_reg     <= held_low_next;
        end
    end

endmodule

@@ src/prefix_synced_sensor_packet_parser.sv @@
// Top level of the prefix-synced sensor packet parser.
//
//  Channel | Direction | Carries
//  --------+-----------+-------------------------------------------------------
//  s_      | in        | one received serial byte per item
//  m_      | out       | one scaled analog value per item, tlast on packet end
//
// Every byte sits in the input register while the parser logic works on it, and
// a completed value is loaded into the output register once that is free, so a
// result passes through the input register and then the output register; one
// byte can be taken in every cycle unless a completed value waits for the output.
// Reset (aresetn low at a clock edge) empties both registers and returns the
// parser to hunting for the prefix with the pedal state up.
// A stalled result holds only bytes that would make a result; other bytes keep
// flowing into the parser.
`timescale 1ns / 1ps

module prefix_synced_sensor_packet_parser
    import pspp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] rx_byte

    output logic              m_tvalid,
    input  logic              m_tready,
    // [2:0] channel, [5:3] analog_index, [21:6] raw_value, [44:22] scaled_value,
    // [45] pedal_down, [46] pedal_changed, [47] zero
    output logic [DATA_W-1:0] m_tdata,
    output logic              m_tlast
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_data_reg;
    logic              m_last_reg;

    pspp_result_t      res;
    logic              out_free;
    logic              advance;

    pspp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .res     (res)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!res.valid || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= advance && res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && advance && res.valid) begin
            m_data_reg <= {1'b0, res.pedal_changed, res.pedal_down, res.scaled_value,
                           res.raw_value, res.analog_index, res.channel};
            m_last_reg <= res.last_of_packet;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the prefix-synced sensor packet parser.
`timescale 1ns / 1ps

module tb;
    import pspp_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [AIDX_W-1:0]   analog_index;
        logic [RAW_W-1:0]    raw_value;
        logic [SCALED_W-1:0] scaled_value;
        logic                pedal_down;
        logic                pedal_changed;
        logic                last_of_packet;
    } reading_t;

    // One byte to send, with its result typed in where it is obvious.
    typedef struct packed {
        logic [7:0] rx;
        logic       known;
        reading_t   want;
    } byte_row_t;

    localparam int STIM_BYTES  = 950;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_SHOWN   = 10;

    // Opening packet: a 0xFF in the channel slot restarts the prefix count,
    // then channel 7 with the pedal pressed and values that include 0, 1023
    // and 0xFFFF (a payload 0xFF is plain data).
    localparam byte_row_t DIR_TAB [26] = '{
        '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
        '{8'h07, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{3'd7, 3'd0, 16'h0000, 23'd0, 1'b1, 1'b1, 1'b0}},
        '{8'hFF, 1'b0, '0},
        '{8'h03, 1'b1, '{3'd7, 3'd1, 16'h03FF, 23'd65536, 1'b1, 1'b1, 1'b0}},
        '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
        '{8'h34, 1'b0, '0}, '{8'h12, 1'b0, '0},
        '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h80, 1'b0, '0},
        '{8'hFE, 1'b0, '0}, '{8'h7F, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{3'd7, 3'd7, 16'h0000, 23'd0, 1'b1, 1'b1, 1'b1}}
    };

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = 8'h00;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;

    prefix_synced_sensor_packet_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Parser state as the predictor sees it.
    int unsigned sync_run    = 0;
    int unsigned parse_pos   = 0;
    logic [2:0]  cur_chan    = '0;
    logic [7:0]  low_hold    = '0;
    logic        pedal_last  = 1'b0;
    logic        pedal_moved = 1'b0;

    reading_t    readings[$];
    byte_row_t   sent_rows[$];
    int unsigned errors      = 0;
    int unsigned checked     = 0;
    int unsigned moves_seen  = 0;
    int unsigned dropped     = 0;
    int unsigned packet_cnt  = 0;
    int unsigned idle_cycles = 0;
    int unsigned sink_hold   = 0;
    int unsigned sink_stall  = 0;
    int unsigned sent_cnt    = 0;
    bit          steady      = 1'b0;

    // Advance the parser by one byte; got is set when a value completes.
    task automatic parse_byte(input logic [7:0] rx, output bit got, output reading_t r);
        logic [15:0] raw;
        logic [63:0] num;
        int unsigned k;
        got = 1'b0;
        r   = '0;
        if (parse_pos == 0) begin
            if (sync_run < PREFIX_LEN || rx >= NUM_CHANNELS) begin
                if (sync_run == PREFIX_LEN) dropped++;
                // A rejected channel byte is rescanned as a possible prefix byte.
                if (rx != SYNC_BYTE) sync_run = 0;
                else if (sync_run < PREFIX_LEN) sync_run++;
                else sync_run = 1;
            end else begin
                cur_chan  = rx[2:0];
                sync_run  = 0;
                parse_pos = 1;
            end
        end else if (parse_pos == 1) begin
            pedal_moved = ((rx != 8'h00) != pedal_last);
            pedal_last  = (rx != 8'h00);
            parse_pos   = 2;
        end else if (parse_pos[0] == 1'b0) begin
            low_hold  = rx;
            parse_pos = parse_pos + 1;
        end else begin
            k   = (parse_pos - 3) >> 1;
            raw = {rx, low_hold};
            num = ({48'd0, raw} << 16) + 64'd511;
            got = 1'b1;
            r.channel        = cur_chan;
            r.analog_index   = k[2:0];
            r.raw_value      = raw;
            r.scaled_value   = SCALED_W'(num / 64'd1023);
            r.pedal_down     = pedal_last;
            r.pedal_changed  = pedal_moved;
            r.last_of_packet = (k + 1 >= NUM_ANALOG);
            parse_pos = r.last_of_packet ? 0 : parse_pos + 1;
            if (r.last_of_packet) sync_run = 0;
        end
    endtask

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (steady || pick < 50) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_row(input byte_row_t row);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        sent_rows.push_back(row);
        sent_cnt++;
        s_tvalid <= 1'b1;
        s_tdata  <= row.rx;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_rand(input logic [7:0] rx);
        send_row('{rx, 1'b0, '0});
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (readings.size() != 0) @(posedge aclk);
    endtask

    // A packet with random content; a few have a broken or long prefix or a
    // channel number out of range.
    task automatic send_packet();
        int unsigned pick;
        int unsigned n_sync;
        logic [7:0]  chan;
        logic [7:0]  pedal;
        logic [15:0] val;
        pick = $urandom_range(0, 99);
        if (pick < 85) n_sync = PREFIX_LEN;
        else if (pick < 93) n_sync = PREFIX_LEN + $urandom_range(1, 3);
        else n_sync = $urandom_range(1, PREFIX_LEN - 1);
        pick = $urandom_range(0, 99);
        if (pick < 85) chan = 8'($urandom_range(0, NUM_CHANNELS - 1));
        else if (pick < 90) chan = SYNC_BYTE;
        else chan = 8'($urandom_range(NUM_CHANNELS, 255));
        pick = $urandom_range(0, 9);
        if (pick < 4) pedal = 8'h00;
        else if (pick < 7) pedal = 8'h01;
        else pedal = 8'($urandom);
        repeat (n_sync) send_rand(SYNC_BYTE);
        send_rand(chan);
        send_rand(pedal);
        for (int i = 0; i < NUM_ANALOG; i++) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       val = 16'h0000;
                1:       val = 16'hFFFF;
                2:       val = 16'd1023;
                3:       val = 16'($urandom_range(1000, 1100));
                default: val = 16'($urandom);
            endcase
            send_rand(val[7:0]);
            send_rand(val[15:8]);
        end
        packet_cnt++;
    endtask

    // Sink side: runs of ready broken by stalls of random length.
    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if (m_tready) begin
            sink_stall = idle_len();
            if (sink_stall != 0) begin
                m_tready  <= 1'b0;
                sink_hold <= sink_stall - 1;
            end else begin
                sink_hold <= $urandom_range(0, 15);
            end
        end else begin
            m_tready  <= 1'b1;
            sink_hold <= $urandom_range(0, 15);
        end
    end

    // Predict on every accepted byte, then check every accepted result.
    byte_row_t mon_row;
    reading_t  mon_pred;
    reading_t  mon_got;
    reading_t  mon_want;
    bit        mon_hit;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                mon_row = sent_rows.pop_front();
                parse_byte(s_tdata, mon_hit, mon_pred);
                if (mon_hit) readings.push_back(mon_row.known ? mon_row.want : mon_pred);
            end
            if (m_tvalid && m_tready) begin
                mon_got.channel        = m_tdata[2:0];
                mon_got.analog_index   = m_tdata[5:3];
                mon_got.raw_value      = m_tdata[21:6];
                mon_got.scaled_value   = m_tdata[44:22];
                mon_got.pedal_down     = m_tdata[45];
                mon_got.pedal_changed  = m_tdata[46];
                mon_got.last_of_packet = m_tlast;
                if (readings.size() == 0) begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("ERROR: result with nothing expected: raw %h", mon_got.raw_value);
                end else begin
                    mon_want = readings.pop_front();
                    checked++;
                    if (mon_want.pedal_changed) moves_seen++;
                    if (mon_got != mon_want) begin
                        errors++;
                        if (errors <= MAX_SHOWN) begin
                            $display("ERROR: result %0d: chan %0d/%0d idx %0d/%0d raw %h/%h",
                                     checked, mon_want.channel, mon_got.channel,
                                     mon_want.analog_index, mon_got.analog_index,
                                     mon_want.raw_value, mon_got.raw_value);
                            $display("       scaled %0d/%0d pedal %b/%b changed %b/%b last %b/%b",
                                     mon_want.scaled_value, mon_got.scaled_value,
                                     mon_want.pedal_down, mon_got.pedal_down,
                                     mon_want.pedal_changed, mon_got.pedal_changed,
                                     mon_want.last_of_packet, mon_got.last_of_packet);
                        end
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("ERROR: no item moved for %0d cycles", STALL_LIMIT);
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < $size(DIR_TAB); i++) send_row(DIR_TAB[i]);
        drain_results();

        while (sent_cnt < STIM_BYTES) begin
            steady = ($urandom_range(0, 7) == 0);
            // Stray bytes between packets, sometimes with 0xFF among them.
            repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 5) : 0)
                send_rand(($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom));
            send_packet();
            if ($urandom_range(0, 11) == 0) drain_results();
        end
        steady = 1'b0;

        drain_results();
        repeat (8) @(posedge aclk);
        $display("Covered %0d packets (%0d dropped on the channel byte), %0d values checked,",
                 packet_cnt, dropped, checked);
        $display("%0d of them flagged a pedal change, with random stalls on both sides.",
                 moves_seen);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
